>>> hw/rtl/cpu8_alu_pkg.sv
// Package: operation codes, shift kinds, flag bit positions and DAA constants for the 8-bit CPU ALU.
package cpu8_alu_pkg;

    typedef enum logic [4:0] {
        FN_ADD    = 5'd0,
        FN_ADC    = 5'd1,
        FN_SUB    = 5'd2,
        FN_SBC    = 5'd3,
        FN_AND    = 5'd4,
        FN_XOR    = 5'd5,
        FN_OR     = 5'd6,
        FN_CP     = 5'd7,
        FN_INC    = 5'd8,
        FN_DEC    = 5'd9,
        FN_RLC    = 5'd10,
        FN_RRC    = 5'd11,
        FN_RL     = 5'd12,
        FN_RR     = 5'd13,
        FN_SLA    = 5'd14,
        FN_SRA    = 5'd15,
        FN_SWAP   = 5'd16,
        FN_SRL    = 5'd17,
        FN_BIT    = 5'd18,
        FN_RES    = 5'd19,
        FN_SET    = 5'd20,
        FN_DAA    = 5'd21,
        FN_CPL    = 5'd22,
        FN_SCF    = 5'd23,
        FN_CCF    = 5'd24,
        FN_ADD16  = 5'd25,
        FN_SPADD  = 5'd26,
        FN_RLCA   = 5'd27,
        FN_RRCA   = 5'd28,
        FN_RLA    = 5'd29,
        FN_RRA    = 5'd30
    } t_func;

    // shift / rotate kinds shared by the CB group and the accumulator rotates
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [7:0] DAA_LIMIT_HI = 8'h99;
    localparam logic [3:0] DAA_LIMIT_LO = 4'h9;
    localparam logic [7:0] DAA_CORR_LO  = 8'h06;
    localparam logic [7:0] DAA_CORR_HI  = 8'h60;

endpackage

>>> hw/rtl/cpu8_alu_with_bcd_flags_unit.sv
// Top level: registered single-pass ALU of an 8-bit handheld CPU with BCD flags.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  request | in        | i_valid / o_ready  | i_func i_acc i_operand i_wide_base
//          |           |                    | i_bit_index i_flags_in
//  result  | out       | o_valid / i_ready  | o_result o_flags_out
//
// Each request is registered in the input register on acceptance, passes the ALU logic, and
// is registered again in the result register, which drives o_valid and the result outputs.
// One request per cycle is sustained while i_ready stays high; both stages advance together when the output is taken.
// If the result is stalled the input register still holds one more request, so o_ready
// drops only when both stages are full and i_ready is low.
// Synchronous active-low reset empties both stages; payload registers are not reset.
module cpu8_alu_with_bcd_flags_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_func,
    input  logic [7:0]  i_acc,
    input  logic [15:0] i_operand,
    input  logic [15:0] i_wide_base,
    input  logic [2:0]  i_bit_index,
    input  logic [3:0]  i_flags_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result,
    output logic [3:0]  o_flags_out
);

    // ---- stage 1: request register ----
    logic        r_s1_valid;
    logic [4:0]  r_func;
    logic [7:0]  r_acc;
    logic [15:0] r_opw;
    logic [15:0] r_base;
    logic [2:0]  r_bi;
    logic [3:0]  r_flags;

    // ---- stage 2: result register ----
    logic        r_out_valid;
    logic [15:0] r_result;
    logic [3:0]  r_flags_out;

    logic        w_s2_ready;
    logic        w_s1_load;
    logic [15:0] n_result;
    logic [3:0]  n_flags_out;

    // a stage may load when it is empty or its content moves on this cycle
    assign w_s2_ready = !r_out_valid || i_ready;
    assign o_ready    = !r_s1_valid || w_s2_ready;
    assign w_s1_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_func  <= i_func;
            r_acc   <= i_acc;
            r_opw   <= i_operand;
            r_base  <= i_wide_base;
            r_bi    <= i_bit_index;
            r_flags <= i_flags_in;
        end
        if (w_s2_ready && r_s1_valid) begin
            r_result    <= n_result;
            r_flags_out <= n_flags_out;
        end
    end

    // ---- ALU logic between the two registers ----
    logic [7:0]  w_v;
    logic        w_fz, w_fn, w_fh, w_fc;
    logic        w_cin;
    logic [8:0]  w_sum9;
    logic [4:0]  w_nib;
    logic [8:0]  w_dif9;
    logic [4:0]  w_nibd;
    logic [7:0]  w_mask;
    logic [2:0]  w_shk;
    logic [7:0]  w_shr;
    logic        w_shc;
    logic [7:0]  w_corr;
    logic        w_dc;
    logic [7:0]  w_daa;
    logic [16:0] w_sum17;
    logic [12:0] w_sum13;
    logic [15:0] w_sext;
    logic [8:0]  w_spl8;
    logic [4:0]  w_spl4;
    logic [7:0]  w_r8;
    logic        w_z8;

    assign w_v  = r_opw[7:0];
    assign w_fz = r_flags[cpu8_alu_pkg::FLAG_Z];
    assign w_fn = r_flags[cpu8_alu_pkg::FLAG_N];
    assign w_fh = r_flags[cpu8_alu_pkg::FLAG_H];
    assign w_fc = r_flags[cpu8_alu_pkg::FLAG_C];

    // carry-in only for ADC / SBC
    assign w_cin = w_fc && ((r_func == cpu8_alu_pkg::FN_ADC) || (r_func == cpu8_alu_pkg::FN_SBC));

    assign w_sum9 = {1'b0, r_acc} + {1'b0, w_v} + {8'd0, w_cin};
    assign w_nib  = {1'b0, r_acc[3:0]} + {1'b0, w_v[3:0]} + {4'd0, w_cin};
    // top bit of a 9/5-bit difference is the borrow
    assign w_dif9 = {1'b0, r_acc} - {1'b0, w_v} - {8'd0, w_cin};
    assign w_nibd = {1'b0, r_acc[3:0]} - {1'b0, w_v[3:0]} - {4'd0, w_cin};

    assign w_mask = 8'd1 << r_bi;

    // accumulator rotates map onto the first four CB kinds
    assign w_shk = (r_func >= cpu8_alu_pkg::FN_RLCA)
                 ? 3'(r_func - cpu8_alu_pkg::FN_RLCA)
                 : 3'(r_func - cpu8_alu_pkg::FN_RLC);

    always_comb begin
        unique case (cpu8_alu_pkg::t_shift'(w_shk))
            cpu8_alu_pkg::SH_RLC:  begin w_shc = r_acc[7]; w_shr = {r_acc[6:0], r_acc[7]}; end
            cpu8_alu_pkg::SH_RRC:  begin w_shc = r_acc[0]; w_shr = {r_acc[0], r_acc[7:1]}; end
            cpu8_alu_pkg::SH_RL:   begin w_shc = r_acc[7]; w_shr = {r_acc[6:0], w_fc}; end
            cpu8_alu_pkg::SH_RR:   begin w_shc = r_acc[0]; w_shr = {w_fc, r_acc[7:1]}; end
            cpu8_alu_pkg::SH_SLA:  begin w_shc = r_acc[7]; w_shr = {r_acc[6:0], 1'b0}; end
            cpu8_alu_pkg::SH_SRA:  begin w_shc = r_acc[0]; w_shr = {r_acc[7], r_acc[7:1]}; end
            cpu8_alu_pkg::SH_SWAP: begin w_shc = 1'b0;     w_shr = {r_acc[3:0], r_acc[7:4]}; end
            cpu8_alu_pkg::SH_SRL:  begin w_shc = r_acc[0]; w_shr = {1'b0, r_acc[7:1]}; end
            default:               begin w_shc = 1'b0;     w_shr = r_acc; end
        endcase
    end

    // decimal adjust: low correction from H or a nibble over nine, high from C or over 0x99
    always_comb begin
        w_corr = 8'd0;
        w_dc   = 1'b0;
        if (w_fh || (!w_fn && (r_acc[3:0] > cpu8_alu_pkg::DAA_LIMIT_LO))) begin
            w_corr = w_corr | cpu8_alu_pkg::DAA_CORR_LO;
        end
        if (w_fc || (!w_fn && (r_acc > cpu8_alu_pkg::DAA_LIMIT_HI))) begin
            w_corr = w_corr | cpu8_alu_pkg::DAA_CORR_HI;
            w_dc   = 1'b1;
        end
        w_daa = w_fn ? (r_acc - w_corr) : (r_acc + w_corr);
    end

    assign w_sum17 = {1'b0, r_base} + {1'b0, r_opw};
    assign w_sum13 = {1'b0, r_base[11:0]} + {1'b0, r_opw[11:0]};
    assign w_sext  = {{8{w_v[7]}}, w_v};
    assign w_spl8  = {1'b0, r_base[7:0]} + {1'b0, w_v};
    assign w_spl4  = {1'b0, r_base[3:0]} + {1'b0, w_v[3:0]};

    always_comb begin
        w_r8        = r_acc;
        n_flags_out = r_flags;
        n_result    = 16'd0;
        unique case (cpu8_alu_pkg::t_func'(r_func))
            cpu8_alu_pkg::FN_ADD, cpu8_alu_pkg::FN_ADC: begin
                w_r8        = w_sum9[7:0];
                n_flags_out = {w_sum9[7:0] == 8'd0, 1'b0, w_nib[4], w_sum9[8]};
            end
            cpu8_alu_pkg::FN_SUB, cpu8_alu_pkg::FN_SBC: begin
                w_r8        = w_dif9[7:0];
                n_flags_out = {w_dif9[7:0] == 8'd0, 1'b1, w_nibd[4], w_dif9[8]};
            end
            cpu8_alu_pkg::FN_CP: begin
                n_flags_out = {w_dif9[7:0] == 8'd0, 1'b1, w_nibd[4], w_dif9[8]};
            end
            cpu8_alu_pkg::FN_AND: begin
                w_r8        = r_acc & w_v;
                n_flags_out = {(r_acc & w_v) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            cpu8_alu_pkg::FN_XOR: begin
                w_r8        = r_acc ^ w_v;
                n_flags_out = {(r_acc ^ w_v) == 8'd0, 3'b000};
            end
            cpu8_alu_pkg::FN_OR: begin
                w_r8        = r_acc | w_v;
                n_flags_out = {(r_acc | w_v) == 8'd0, 3'b000};
            end
            cpu8_alu_pkg::FN_INC: begin
                w_r8        = r_acc + 8'd1;
                n_flags_out = {r_acc == 8'hFF, 1'b0, r_acc[3:0] == 4'hF, w_fc};
            end
            cpu8_alu_pkg::FN_DEC: begin
                w_r8        = r_acc - 8'd1;
                n_flags_out = {r_acc == 8'h01, 1'b1, r_acc[3:0] == 4'h0, w_fc};
            end
            cpu8_alu_pkg::FN_RLC, cpu8_alu_pkg::FN_RRC, cpu8_alu_pkg::FN_RL,
            cpu8_alu_pkg::FN_RR, cpu8_alu_pkg::FN_SLA, cpu8_alu_pkg::FN_SRA,
            cpu8_alu_pkg::FN_SWAP, cpu8_alu_pkg::FN_SRL: begin
                w_r8        = w_shr;
                n_flags_out = {w_shr == 8'd0, 2'b00, w_shc};
            end
            cpu8_alu_pkg::FN_RLCA, cpu8_alu_pkg::FN_RRCA, cpu8_alu_pkg::FN_RLA,
            cpu8_alu_pkg::FN_RRA: begin
                // Z always cleared on the accumulator forms
                w_r8        = w_shr;
                n_flags_out = {3'b000, w_shc};
            end
            cpu8_alu_pkg::FN_BIT: begin
                n_flags_out = {(r_acc & w_mask) == 8'd0, 1'b0, 1'b1, w_fc};
            end
            cpu8_alu_pkg::FN_RES: w_r8 = r_acc & ~w_mask;
            cpu8_alu_pkg::FN_SET: w_r8 = r_acc | w_mask;
            cpu8_alu_pkg::FN_DAA: begin
                w_r8        = w_daa;
                n_flags_out = {w_daa == 8'd0, w_fn, 1'b0, w_dc};
            end
            cpu8_alu_pkg::FN_CPL: begin
                w_r8        = ~r_acc;
                n_flags_out = {w_fz, 1'b1, 1'b1, w_fc};
            end
            cpu8_alu_pkg::FN_SCF: n_flags_out = {w_fz, 2'b00, 1'b1};
            cpu8_alu_pkg::FN_CCF: n_flags_out = {w_fz, 2'b00, !w_fc};
            cpu8_alu_pkg::FN_ADD16, cpu8_alu_pkg::FN_SPADD: ;
            default: ; // unused code: acc and flags pass through
        endcase

        if (r_func == cpu8_alu_pkg::FN_ADD16) begin
            n_result    = w_sum17[15:0];
            n_flags_out = {w_fz, 1'b0, w_sum13[12], w_sum17[16]};
        end else if (r_func == cpu8_alu_pkg::FN_SPADD) begin
            n_result    = r_base + w_sext;
            n_flags_out = {2'b00, w_spl4[4], w_spl8[8]};
        end else begin
            n_result = {8'd0, w_r8};
        end
    end

    assign o_valid     = r_out_valid;
    assign o_result    = r_result;
    assign o_flags_out = r_flags_out;

    // ---- assertions ----
    // a request taken always occupies the input register next cycle
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_load |=> r_s1_valid)
        else $error("accepted request not held in input register");

    // a request in stage 1 moves to the result register when that stage can take it
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_s2_ready |=> r_out_valid)
        else $error("stage 1 request lost on its way to the result register");

    // taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_ready && !r_s1_valid |=> !r_out_valid)
        else $error("result repeated after it was taken");

    // input side cannot be blocked while the result register is free
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_ready)
        else $error("request stalled with a free pipeline");

endmodule

>>> tb/testbench.sv
// Testbench for the CPU ALU: random and directed requests checked against a bit-exact predictor.

typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags;
} t_alu_outcome;

// Predicts each ALU outcome and holds the outcomes still owed by the block.
class alu_outcome_board;
    t_alu_outcome pending_outcomes[$];
    int unsigned  failures;
    int unsigned  reported;
    int unsigned  requests_logged;
    int unsigned  outcomes_checked;
    logic [31:0]  funcs_seen;

    function new();
        failures         = 0;
        reported         = 0;
        requests_logged  = 0;
        outcomes_checked = 0;
        funcs_seen       = '0;
    endfunction

    function int unsigned outstanding();
        return pending_outcomes.size();
    endfunction

    function t_alu_outcome compute_outcome(logic [4:0] func, logic [7:0] acc,
                                           logic [15:0] operand, logic [15:0] base,
                                           logic [2:0] bi, logic [3:0] flags);
        t_alu_outcome o;
        logic [7:0]   v;
        logic [7:0]   r8;
        logic [7:0]   corr;
        logic [8:0]   t9;
        logic [16:0]  t17;
        logic [4:0]   h5;
        logic [12:0]  h13;
        logic [2:0]   kind;
        logic         fz, fn, fh, fc, cin, c;

        v  = operand[7:0];
        fz = flags[cpu8_alu_pkg::FLAG_Z];
        fn = flags[cpu8_alu_pkg::FLAG_N];
        fh = flags[cpu8_alu_pkg::FLAG_H];
        fc = flags[cpu8_alu_pkg::FLAG_C];
        o.result = {8'h00, acc};
        o.flags  = flags;
        case (func)
            cpu8_alu_pkg::FN_ADD, cpu8_alu_pkg::FN_ADC: begin
                cin = (func == cpu8_alu_pkg::FN_ADC) ? fc : 1'b0;
                t9  = {1'b0, acc} + {1'b0, v} + {8'h00, cin};
                h5  = {1'b0, acc[3:0]} + {1'b0, v[3:0]} + {4'h0, cin};
                o.result = {8'h00, t9[7:0]};
                o.flags  = {t9[7:0] == 8'h00, 1'b0, h5[4], t9[8]};
            end
            cpu8_alu_pkg::FN_SUB, cpu8_alu_pkg::FN_SBC, cpu8_alu_pkg::FN_CP: begin
                cin = (func == cpu8_alu_pkg::FN_SBC) ? fc : 1'b0;
                t9  = {1'b0, acc} - {1'b0, v} - {8'h00, cin};
                o.flags = {t9[7:0] == 8'h00, 1'b1,
                           {1'b0, acc[3:0]} < ({1'b0, v[3:0]} + {4'h0, cin}),
                           {1'b0, acc} < ({1'b0, v} + {8'h00, cin})};
                if (func != cpu8_alu_pkg::FN_CP) begin
                    o.result = {8'h00, t9[7:0]};
                end
            end
            cpu8_alu_pkg::FN_AND: begin
                r8 = acc & v;
                o.result = {8'h00, r8};
                o.flags  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            cpu8_alu_pkg::FN_XOR, cpu8_alu_pkg::FN_OR: begin
                r8 = (func == cpu8_alu_pkg::FN_XOR) ? (acc ^ v) : (acc | v);
                o.result = {8'h00, r8};
                o.flags  = {r8 == 8'h00, 3'b000};
            end
            cpu8_alu_pkg::FN_INC: begin
                r8 = acc + 8'h01;
                o.result = {8'h00, r8};
                o.flags  = {r8 == 8'h00, 1'b0, acc[3:0] == 4'hF, fc};
            end
            cpu8_alu_pkg::FN_DEC: begin
                r8 = acc - 8'h01;
                o.result = {8'h00, r8};
                o.flags  = {r8 == 8'h00, 1'b1, acc[3:0] == 4'h0, fc};
            end
            cpu8_alu_pkg::FN_RLC, cpu8_alu_pkg::FN_RRC, cpu8_alu_pkg::FN_RL,
            cpu8_alu_pkg::FN_RR, cpu8_alu_pkg::FN_SLA, cpu8_alu_pkg::FN_SRA,
            cpu8_alu_pkg::FN_SWAP, cpu8_alu_pkg::FN_SRL,
            cpu8_alu_pkg::FN_RLCA, cpu8_alu_pkg::FN_RRCA, cpu8_alu_pkg::FN_RLA,
            cpu8_alu_pkg::FN_RRA: begin
                kind = (func >= cpu8_alu_pkg::FN_RLCA) ? 3'(func - cpu8_alu_pkg::FN_RLCA)
                                                       : 3'(func - cpu8_alu_pkg::FN_RLC);
                case (kind)
                    cpu8_alu_pkg::SH_RLC:  begin c = acc[7]; r8 = {acc[6:0], acc[7]}; end
                    cpu8_alu_pkg::SH_RRC:  begin c = acc[0]; r8 = {acc[0], acc[7:1]}; end
                    cpu8_alu_pkg::SH_RL:   begin c = acc[7]; r8 = {acc[6:0], fc}; end
                    cpu8_alu_pkg::SH_RR:   begin c = acc[0]; r8 = {fc, acc[7:1]}; end
                    cpu8_alu_pkg::SH_SLA:  begin c = acc[7]; r8 = {acc[6:0], 1'b0}; end
                    cpu8_alu_pkg::SH_SRA:  begin c = acc[0]; r8 = {acc[7], acc[7:1]}; end
                    cpu8_alu_pkg::SH_SWAP: begin c = 1'b0;   r8 = {acc[3:0], acc[7:4]}; end
                    default:               begin c = acc[0]; r8 = {1'b0, acc[7:1]}; end
                endcase
                o.result = {8'h00, r8};
                // accumulator rotates always clear Z
                o.flags  = {(func >= cpu8_alu_pkg::FN_RLCA) ? 1'b0 : (r8 == 8'h00), 2'b00, c};
            end
            cpu8_alu_pkg::FN_BIT: begin
                o.flags = {acc[bi] == 1'b0, 1'b0, 1'b1, fc};
            end
            cpu8_alu_pkg::FN_RES: begin
                o.result = {8'h00, acc & ~(8'h01 << bi)};
            end
            cpu8_alu_pkg::FN_SET: begin
                o.result = {8'h00, acc | (8'h01 << bi)};
            end
            cpu8_alu_pkg::FN_DAA: begin
                corr = 8'h00;
                c    = 1'b0;
                if (fh || (!fn && acc[3:0] > cpu8_alu_pkg::DAA_LIMIT_LO)) begin
                    corr = corr | cpu8_alu_pkg::DAA_CORR_LO;
                end
                if (fc || (!fn && acc > cpu8_alu_pkg::DAA_LIMIT_HI)) begin
                    corr = corr | cpu8_alu_pkg::DAA_CORR_HI;
                    c    = 1'b1;
                end
                r8 = fn ? (acc - corr) : (acc + corr);
                o.result = {8'h00, r8};
                o.flags  = {r8 == 8'h00, fn, 1'b0, c};
            end
            cpu8_alu_pkg::FN_CPL: begin
                o.result = {8'h00, ~acc};
                o.flags  = {fz, 1'b1, 1'b1, fc};
            end
            cpu8_alu_pkg::FN_SCF: o.flags = {fz, 1'b0, 1'b0, 1'b1};
            cpu8_alu_pkg::FN_CCF: o.flags = {fz, 1'b0, 1'b0, ~fc};
            cpu8_alu_pkg::FN_ADD16: begin
                t17 = {1'b0, base} + {1'b0, operand};
                h13 = {1'b0, base[11:0]} + {1'b0, operand[11:0]};
                o.result = t17[15:0];
                o.flags  = {fz, 1'b0, h13[12], t17[16]};
            end
            cpu8_alu_pkg::FN_SPADD: begin
                h5 = {1'b0, base[3:0]} + {1'b0, v[3:0]};
                t9 = {1'b0, base[7:0]} + {1'b0, v};
                o.result = base + {{8{v[7]}}, v};
                o.flags  = {2'b00, h5[4], t9[8]};
            end
            default: ; // unused code passes acc and flags through
        endcase
        return o;
    endfunction

    function void log_request(logic [4:0] func, logic [7:0] acc, logic [15:0] operand,
                              logic [15:0] base, logic [2:0] bi, logic [3:0] flags);
        pending_outcomes.push_back(compute_outcome(func, acc, operand, base, bi, flags));
        funcs_seen[func] = 1'b1;
        requests_logged++;
    endfunction

    function void check_outcome(logic [15:0] result, logic [3:0] flags);
        t_alu_outcome want;
        if (pending_outcomes.size() == 0) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("unexpected result: result=%h flags=%b", result, flags);
            end
            return;
        end
        want = pending_outcomes.pop_front();
        outcomes_checked++;
        if (result !== want.result || flags !== want.flags) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("mismatch on result %0d: result exp %h got %h, flags exp %b got %b",
                         outcomes_checked, want.result, result, want.flags, flags);
            end
        end
    endfunction
endclass

module testbench;
    localparam logic [4:0] FN_UNUSED    = 5'd31;
    localparam int         RANDOM_HALF  = 275;
    localparam int         IDLE_LIMIT   = 1000; // cycles with no handshake before giving up
    localparam int         LONG_HOLD    = 80;   // receiver stall, enough to back up the pipe
    localparam int         HOLD_AFTER   = 150;  // results seen before the long stall

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [4:0]  i_func;
    logic [7:0]  i_acc;
    logic [15:0] i_operand;
    logic [15:0] i_wide_base;
    logic [2:0]  i_bit_index;
    logic [3:0]  i_flags_in;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_result;
    logic [3:0]  o_flags_out;

    alu_outcome_board board;
    int unsigned      sent;
    bit               long_hold_done;

    cpu8_alu_with_bcd_flags_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_acc       (i_acc),
        .i_operand   (i_operand),
        .i_wide_base (i_wide_base),
        .i_bit_index (i_bit_index),
        .i_flags_in  (i_flags_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .o_flags_out (o_flags_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Byte with a bias towards the corners that flip carries and zero flags.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return 8'($urandom_range(0, 15) * 17); // repeated nibbles, DAA corners
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0FFF;
            3:       return 16'h00FF;
            4:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one request after an idle gap, then wait for the handshake.
    // Called straight after the previous acceptance, so valid stays high when gap is 0.
    task automatic offer_request(input logic [4:0] f, input logic [7:0] a,
                                 input logic [15:0] op, input logic [15:0] base,
                                 input logic [2:0] bi, input logic [3:0] fl, input int gap);
        if (gap > 0) begin
            @(negedge i_clk) i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_func      = f;
        i_acc       = a;
        i_operand   = op;
        i_wide_base = base;
        i_bit_index = bi;
        i_flags_in  = fl;
        i_valid     = 1'b1;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        board.log_request(i_func, i_acc, i_operand, i_wide_base, i_bit_index, i_flags_in);
        sent++;
    endtask

    task automatic send_random(input int count);
        int gap;
        for (int k = 0; k < count; k++) begin
            // every 120 requests, a burst of 30 with no sender idling
            gap = ((sent % 120) < 30) ? 0 : $urandom_range(0, 12);
            offer_request(5'($urandom_range(0, 31)), pick_byte(), pick_word(), pick_word(),
                          3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), gap);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk) i_valid = 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, bursts of continuous ready, and one long hold-off
    // while the sender keeps offering, so both pipeline stages fill and o_ready drops.
    initial begin
        int gap;
        i_ready        = 1'b0;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!long_hold_done && board.outcomes_checked >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                gap = LONG_HOLD;
            end else if ((board.outcomes_checked % 80) < 20) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 12);
            end
            if (gap > 0) begin
                @(negedge i_clk) i_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_ready = 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            board.check_outcome(o_result, o_flags_out);
        end
    end

    // Watchdog: gives up after too many cycles without any handshake.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("[cpu8_alu_with_bcd_flags_unit] ERROR");
        $finish;
    end

    initial begin
        logic [7:0]  acc_corner  [4];
        logic [15:0] op_corner   [4];
        logic [15:0] base_corner [4];
        int unsigned leftover;

        acc_corner  = '{8'hFF, 8'h80, 8'h01, 8'h00};
        op_corner   = '{16'hFFFF, 16'h0001, 16'h0080, 16'h8000};
        base_corner = '{16'hFFFF, 16'h0FFF, 16'h0000, 16'h8000};
        board       = new();
        sent        = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = '0;
        i_acc       = '0;
        i_operand   = '0;
        i_wide_base = '0;
        i_bit_index = '0;
        i_flags_in  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // Directed: every code including the unused one, at corner operands.
        // Odd codes get all flags set, which makes DAA run as the after-subtraction
        // case with carry in; RLCA lands on acc zero to show Z cleared;
        // SP plus offset takes the most negative offset from base zero.
        for (int f = 0; f < 32; f++) begin
            offer_request(5'(f), acc_corner[f % 4], op_corner[f % 4], base_corner[f % 4],
                          3'(f % 8), (f % 2 == 1) ? 4'hF : 4'h0, 0);
        end
        offer_request(cpu8_alu_pkg::FN_DAA, 8'h9A, 16'h0000, 16'h0000, 3'd0, 4'h0, 0);
        offer_request(cpu8_alu_pkg::FN_ADD16, 8'h00, 16'hFFFF, 16'hFFFF, 3'd7, 4'h8, 0);
        offer_request(FN_UNUSED, 8'h5A, 16'hFFFF, 16'hFFFF, 3'd7, 4'hA, 0);

        send_random(RANDOM_HALF);
        // sender pause: everything owed comes back before the second half
        drain_results();
        send_random(RANDOM_HALF);

        drain_results();
        repeat (8) @(posedge i_clk);
        leftover = board.outstanding();

        $display("%0d requests sent, %0d results checked, %0d of 32 operation codes seen",
                 sent, board.outcomes_checked, $countones(board.funcs_seen));
        $display("failures: %0d, results still owed: %0d", board.failures, leftover);
        if (board.failures == 0 && leftover == 0) begin
            $display("[cpu8_alu_with_bcd_flags_unit] OK");
        end else begin
            $display("[cpu8_alu_with_bcd_flags_unit] ERROR");
        end
        $finish;
    end
endmodule
